[rtl/bffa_pkg.sv]
// Shared constants, payload types and controller states of the bitmap first-fit allocator.
package bffa_pkg;

   localparam int SEGMENT_LOG2           = 14;
   localparam int RESERVED_WORDS_DEFAULT = 32;

   localparam int UNIT_BYTES_LOG2 = 4;
   localparam int UNIT_W          = SEGMENT_LOG2 - UNIT_BYTES_LOG2;
   localparam int UNIT_COUNT      = 1 << UNIT_W;
   localparam int SIZE_W          = SEGMENT_LOG2 + 1;
   localparam int OFFSET_W        = SEGMENT_LOG2;
   localparam int NEED_W          = SIZE_W - UNIT_BYTES_LOG2 + 1;
   localparam int RUN_W           = UNIT_W + 1;
   localparam int FRAG_W          = 24;
   localparam int STATUS_W        = 2;

   localparam int MARK_W          = 2;
   localparam int WORD_UNITS_LOG2 = 3;
   localparam int WORD_UNITS      = 1 << WORD_UNITS_LOG2;
   localparam int WORD_W          = WORD_UNITS * MARK_W;
   localparam int WORD_COUNT      = UNIT_COUNT / WORD_UNITS;
   localparam int ADDR_W          = UNIT_W - WORD_UNITS_LOG2;

   localparam logic [MARK_W-1:0] MARK_FREE  = 2'b11;
   localparam logic [MARK_W-1:0] MARK_START = 2'b01;
   localparam logic [MARK_W-1:0] MARK_CONT  = 2'b00;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE = 2'd2;

   typedef struct packed {
      logic                req_type;
      logic [SIZE_W-1:0]   size_bytes;
      logic [OFFSET_W-1:0] block_offset_in;
   } bffa_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] block_offset_out;
      logic [FRAG_W-1:0]   fragmentation_total;
   } bffa_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LOAD,
      ST_MARK,
      ST_DONE
   } bffa_state_type;

endpackage

[rtl/bffa_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module bffa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bitmap_first_fit_allocator.sv]
// Top level of the bitmap first-fit allocator with its mark memory and controller.
//
// A request carries req_type (allocate or free), size_bytes and block_offset_in on a
// valid/ready channel; each request gives exactly one response with status,
// block_offset_out and fragmentation_total on the rsp_ channel.
// The unit marks live in one RAM of eight two-bit marks per word.
// An allocate reads one word per cycle from the bottom of the segment, and then rewrites
// the words the new block covers, one per cycle.
// A free rewrites the block's words one per cycle, starting at the block's first word.
// One request is in progress at a time; req_ready is high only when the block is idle.
// A finished response sits in an output register, so a new request is taken while the
// previous response still waits; if the receiver stalls, the next response holds the
// controller until the output register is free.
// After reset the block writes the initial marks into every word of the RAM and
// keeps req_ready low until that pass is done; the fragmentation total resets to zero.
module bitmap_first_fit_allocator #(
   parameter int RESERVED_WORDS = bffa_pkg::RESERVED_WORDS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bffa_pkg::bffa_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bffa_pkg::bffa_rsp_type rsp_data
);

   import bffa_pkg::*;

   localparam int HEAD_RAW   = ((1 << (SEGMENT_LOG2 - 9)) + RESERVED_WORDS + 1) / 2;
   localparam int HEAD_UNITS = (HEAD_RAW < UNIT_COUNT) ? HEAD_RAW : UNIT_COUNT;
   localparam logic [UNIT_W:0]   HEAD_LIMIT = (UNIT_W + 1)'(HEAD_UNITS);
   localparam logic [ADDR_W-1:0] LAST_WORD  = ADDR_W'(WORD_COUNT - 1);

   bffa_state_type state_ff, state_in;

   logic [ADDR_W-1:0]   cur_ff, cur_in;
   logic [RUN_W-1:0]    run_ff, run_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [UNIT_W-1:0]   lo_ff, lo_in;
   logic [UNIT_W-1:0]   hi_ff, hi_in;
   logic                kind_ff, kind_in;
   logic                first_ff, first_in;
   logic [FRAG_W-1:0]   frag_ff, frag_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [OFFSET_W-1:0] result_off_ff, result_off_in;
   logic                rsp_valid_ff, rsp_valid_in;
   bffa_rsp_type        rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic                accept;
   logic                rsp_free;
   logic [UNIT_W-1:0]   req_unit;
   logic [SIZE_W:0]     size_sum;
   logic [NEED_W-1:0]   need_calc;
   logic [3:0]          slack;
   logic [FRAG_W:0]     frag_sum;
   logic [FRAG_W-1:0]   frag_sat;
   logic                size_zero;
   logic                free_req_ok;

   logic [RUN_W-1:0]           scan_run;
   logic                       scan_found;
   logic [WORD_UNITS_LOG2-1:0] scan_pos;
   logic [UNIT_W-1:0]          scan_idx;
   logic [NEED_W-1:0]          scan_lo_wide;

   logic [WORD_W-1:0] clear_word;
   logic [WORD_W-1:0] alloc_word;
   logic [WORD_W-1:0] free_word;
   logic              free_chain;
   logic              free_start_ok;
   logic [UNIT_W-1:0] unit_idx;

   bffa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORD_COUNT)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_unit    = req_data.block_offset_in[OFFSET_W-1:UNIT_BYTES_LOG2];
   assign size_sum    = {1'b0, req_data.size_bytes} + (SIZE_W + 1)'((1 << UNIT_BYTES_LOG2) - 1);
   assign need_calc   = size_sum[SIZE_W:UNIT_BYTES_LOG2];
   assign slack       = 4'd0 - req_data.size_bytes[UNIT_BYTES_LOG2-1:0];
   assign frag_sum    = {1'b0, frag_ff} + (FRAG_W + 1)'(slack);
   assign frag_sat    = frag_sum[FRAG_W] ? {FRAG_W{1'b1}} : frag_sum[FRAG_W-1:0];
   assign size_zero   = (req_data.size_bytes == '0);
   assign free_req_ok = (req_data.block_offset_in[UNIT_BYTES_LOG2-1:0] == '0) &&
                        ({1'b0, req_unit} >= HEAD_LIMIT);

   always_comb begin
      for (int j = 0; j < WORD_UNITS; j++) begin
         if ((int'(cur_ff) * WORD_UNITS + j) == 0) begin
            clear_word[j*MARK_W +: MARK_W] = MARK_START;
         end else if ((int'(cur_ff) * WORD_UNITS + j) < HEAD_UNITS) begin
            clear_word[j*MARK_W +: MARK_W] = MARK_CONT;
         end else begin
            clear_word[j*MARK_W +: MARK_W] = MARK_FREE;
         end
      end
   end

   always_comb begin
      scan_run   = run_ff;
      scan_found = 1'b0;
      scan_pos   = '0;
      for (int j = 0; j < WORD_UNITS; j++) begin
         if (rd_data[j*MARK_W +: MARK_W] == MARK_FREE) begin
            scan_run = scan_run + 1'b1;
         end else begin
            scan_run = '0;
         end
         if (!scan_found && (NEED_W'(scan_run) == need_ff)) begin
            scan_found = 1'b1;
            scan_pos   = WORD_UNITS_LOG2'(j);
         end
      end
   end

   assign scan_idx     = {cur_ff, scan_pos};
   assign scan_lo_wide = NEED_W'(scan_idx) + NEED_W'(1) - need_ff;

   always_comb begin
      unit_idx = '0;
      for (int j = 0; j < WORD_UNITS; j++) begin
         unit_idx = {cur_ff, WORD_UNITS_LOG2'(j)};
         if ((unit_idx >= lo_ff) && (unit_idx <= hi_ff)) begin
            alloc_word[j*MARK_W +: MARK_W] = (unit_idx == lo_ff) ? MARK_START : MARK_CONT;
         end else begin
            alloc_word[j*MARK_W +: MARK_W] = rd_data[j*MARK_W +: MARK_W];
         end
      end
   end

   always_comb begin
      free_chain = !first_ff;
      for (int j = 0; j < WORD_UNITS; j++) begin
         if (first_ff && (WORD_UNITS_LOG2'(j) == lo_ff[WORD_UNITS_LOG2-1:0])) begin
            free_word[j*MARK_W +: MARK_W] = MARK_FREE;
            free_chain = 1'b1;
         end else if (free_chain && (rd_data[j*MARK_W +: MARK_W] == MARK_CONT)) begin
            free_word[j*MARK_W +: MARK_W] = MARK_FREE;
         end else begin
            free_word[j*MARK_W +: MARK_W] = rd_data[j*MARK_W +: MARK_W];
            free_chain = 1'b0;
         end
      end
   end

   assign free_start_ok =
      (rd_data[int'(lo_ff[WORD_UNITS_LOG2-1:0]) * MARK_W +: MARK_W] == MARK_START);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cur_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == REQ_ALLOC) begin
                  state_in = size_zero ? ST_DONE : ST_SCAN;
               end else begin
                  state_in = free_req_ok ? ST_MARK : ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_found) begin
               state_in = ST_LOAD;
            end else if (cur_ff == LAST_WORD) begin
               state_in = ST_DONE;
            end
         end
         ST_LOAD: begin
            state_in = ST_MARK;
         end
         ST_MARK: begin
            if (kind_ff == REQ_ALLOC) begin
               if (cur_ff == hi_ff[UNIT_W-1:WORD_UNITS_LOG2]) begin
                  state_in = ST_DONE;
               end
            end else if (first_ff && !free_start_ok) begin
               state_in = ST_DONE;
            end else if (!free_chain || (cur_ff == LAST_WORD)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cur_in        = cur_ff;
      run_in        = run_ff;
      need_in       = need_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      kind_in       = kind_ff;
      first_in      = first_ff;
      frag_in       = frag_ff;
      status_in     = status_ff;
      result_off_in = result_off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = alloc_word;
      rd_en         = 1'b0;
      rd_addr       = cur_ff + 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = clear_word;
            cur_in  = cur_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in       = req_data.req_type;
               result_off_in = '0;
               if (req_data.req_type == REQ_ALLOC) begin
                  if (size_zero) begin
                     status_in = STATUS_ZERO_SIZE;
                  end else begin
                     status_in = STATUS_NO_SPACE;
                     frag_in   = frag_sat;
                     need_in   = need_calc;
                     run_in    = '0;
                     cur_in    = '0;
                     rd_en     = 1'b1;
                     rd_addr   = '0;
                  end
               end else begin
                  status_in = STATUS_OK;
                  if (free_req_ok) begin
                     rd_en    = 1'b1;
                     rd_addr  = req_unit[UNIT_W-1:WORD_UNITS_LOG2];
                     cur_in   = req_unit[UNIT_W-1:WORD_UNITS_LOG2];
                     lo_in    = req_unit;
                     first_in = 1'b1;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_found) begin
               lo_in = scan_lo_wide[UNIT_W-1:0];
               hi_in = scan_idx;
            end else if (cur_ff != LAST_WORD) begin
               rd_en  = 1'b1;
               cur_in = cur_ff + 1'b1;
               run_in = scan_run;
            end
         end
         ST_LOAD: begin
            rd_en   = 1'b1;
            rd_addr = lo_ff[UNIT_W-1:WORD_UNITS_LOG2];
            cur_in  = lo_ff[UNIT_W-1:WORD_UNITS_LOG2];
         end
         ST_MARK: begin
            if (kind_ff == REQ_ALLOC) begin
               wr_en = 1'b1;
               if (cur_ff == hi_ff[UNIT_W-1:WORD_UNITS_LOG2]) begin
                  status_in     = STATUS_OK;
                  result_off_in = {lo_ff, UNIT_BYTES_LOG2'(0)};
               end else begin
                  rd_en  = 1'b1;
                  cur_in = cur_ff + 1'b1;
               end
            end else if (!(first_ff && !free_start_ok)) begin
               wr_en    = 1'b1;
               wr_data  = free_word;
               first_in = 1'b0;
               rd_en    = 1'b1;
               cur_in   = cur_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in                    = 1'b1;
               rsp_data_in.status              = status_ff;
               rsp_data_in.block_offset_out    = result_off_ff;
               rsp_data_in.fragmentation_total = frag_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         frag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         frag_ff      <= frag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff        <= run_in;
      need_ff       <= need_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      kind_ff       <= kind_in;
      first_ff      <= first_in;
      status_ff     <= status_in;
      result_off_ff <= result_off_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

[rtl/bffa_checker.sv]
// Port-level assertions for the bitmap first-fit allocator and their bind.
module bffa_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input bffa_pkg::bffa_rsp_type rsp_data
);

   import bffa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during the initial mark pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in progress");

   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> rsp_data.block_offset_out == '0)
      else $error("failed request returned a nonzero offset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK) || (rsp_data.status == STATUS_NO_SPACE) ||
                    (rsp_data.status == STATUS_ZERO_SIZE))
      else $error("response carries an unknown status");

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (.*);

[verif/testbench.sv]
// Self-checking testbench for the bitmap first-fit allocator: directed table, random traffic.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bffa_pkg::*;

   localparam int UNIT_BYTES    = 1 << UNIT_BYTES_LOG2;
   localparam int HEAD_RAW      = ((1 << (SEGMENT_LOG2 - 9)) + RESERVED_WORDS_DEFAULT + 1) / 2;
   localparam int HEAD_UNITS    = (HEAD_RAW < UNIT_COUNT) ? HEAD_RAW : UNIT_COUNT;
   localparam int FRAG_MAX      = (1 << FRAG_W) - 1;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 1145;
   localparam int CALM_ITEMS    = 150;
   localparam int DRAIN_CYCLES  = 300;
   localparam int STALL_LIMIT   = 5000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic         known;
      bffa_req_type rq;
      bffa_rsp_type rs;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   bffa_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   bffa_rsp_type rsp_data;

   logic [MARK_W-1:0] unit_mark_copy [UNIT_COUNT];
   logic [FRAG_W-1:0] frag_total_copy;
   bffa_rsp_type      expected_rsp_q [$];
   plan_row_type      directed_plan [DIRECTED_ROWS];

   int mismatch_count = 0;
   int response_count = 0;
   int quiet_cycles   = 0;
   int sender_gap_pct = 20;
   int sink_stall_left = 0;
   bit sink_busy_mode = 1'b1;
   bit calm_tail = 1'b0;

   bitmap_first_fit_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic plan_row_type plan_entry(input logic known, input logic kind,
                                               input int size, input int offs,
                                               input logic [STATUS_W-1:0] status,
                                               input int out_off, input int frag);
      plan_row_type row;
      row.known                  = known;
      row.rq.req_type            = kind;
      row.rq.size_bytes          = SIZE_W'(size);
      row.rq.block_offset_in     = OFFSET_W'(offs);
      row.rs.status              = status;
      row.rs.block_offset_out    = OFFSET_W'(out_off);
      row.rs.fragmentation_total = FRAG_W'(frag);
      return row;
   endfunction

   function automatic void clear_allocator_copy();
      for (int u = 0; u < UNIT_COUNT; u++) begin
         if (u == 0) begin
            unit_mark_copy[u] = MARK_START;
         end else if (u < HEAD_UNITS) begin
            unit_mark_copy[u] = MARK_CONT;
         end else begin
            unit_mark_copy[u] = MARK_FREE;
         end
      end
      frag_total_copy = '0;
   endfunction

   function automatic bffa_rsp_type apply_request(input bffa_req_type rq);
      bffa_rsp_type rs;
      int need;
      int run;
      int first;
      int u;
      bit found;
      logic [FRAG_W:0] sum;
      rs.status = STATUS_OK;
      rs.block_offset_out = '0;
      if (rq.req_type == REQ_ALLOC) begin
         if (rq.size_bytes == 0) begin
            rs.status = STATUS_ZERO_SIZE;
         end else begin
            need = (int'(rq.size_bytes) + UNIT_BYTES - 1) / UNIT_BYTES;
            sum = frag_total_copy + (need * UNIT_BYTES - int'(rq.size_bytes));
            frag_total_copy = (sum > FRAG_MAX) ? FRAG_W'(FRAG_MAX) : sum[FRAG_W-1:0];
            run = 0;
            first = 0;
            found = 1'b0;
            for (u = HEAD_UNITS; u < UNIT_COUNT && !found; u++) begin
               run = (unit_mark_copy[u] == MARK_FREE) ? run + 1 : 0;
               if (run == need) begin
                  first = u + 1 - need;
                  found = 1'b1;
               end
            end
            if (found) begin
               unit_mark_copy[first] = MARK_START;
               for (u = first + 1; u < first + need; u++) begin
                  unit_mark_copy[u] = MARK_CONT;
               end
               rs.block_offset_out = OFFSET_W'(first * UNIT_BYTES);
            end else begin
               rs.status = STATUS_NO_SPACE;
            end
         end
      end else begin
         u = int'(rq.block_offset_in) / UNIT_BYTES;
         if (rq.block_offset_in[UNIT_BYTES_LOG2-1:0] == 0 && u >= HEAD_UNITS
             && unit_mark_copy[u] == MARK_START) begin
            unit_mark_copy[u] = MARK_FREE;
            u++;
            while (u < UNIT_COUNT && unit_mark_copy[u] == MARK_CONT) begin
               unit_mark_copy[u] = MARK_FREE;
               u++;
            end
         end
      end
      rs.fragmentation_total = frag_total_copy;
      return rs;
   endfunction

   function automatic int pick_live_block();
      int starts [$];
      for (int u = HEAD_UNITS; u < UNIT_COUNT; u++) begin
         if (unit_mark_copy[u] == MARK_START) begin
            starts.push_back(u);
         end
      end
      if (starts.size() == 0) begin
         return -1;
      end
      return starts[$urandom_range(starts.size() - 1)];
   endfunction

   function automatic bffa_req_type random_request();
      bffa_req_type rq;
      int pick;
      int band;
      int live;
      rq.req_type        = REQ_ALLOC;
      rq.size_bytes      = SIZE_W'($urandom);
      rq.block_offset_in = OFFSET_W'($urandom);
      pick = $urandom_range(99);
      live = pick_live_block();
      if (pick < 4) begin
         rq.size_bytes = '0;
      end else if (pick < 50 || (pick < 85 && live < 0)) begin
         band = $urandom_range(99);
         if (band < 60) begin
            rq.size_bytes = SIZE_W'($urandom_range(128, 1));
         end else if (band < 85) begin
            rq.size_bytes = SIZE_W'($urandom_range(1024, 129));
         end else if (band < 97) begin
            rq.size_bytes = SIZE_W'($urandom_range(8192, 1025));
         end else begin
            rq.size_bytes = SIZE_W'($urandom_range(16384, 8193));
         end
      end else if (pick < 85) begin
         rq.req_type = REQ_FREE;
         rq.block_offset_in = OFFSET_W'(live * UNIT_BYTES);
      end else if (pick < 92) begin
         rq.req_type = REQ_FREE;
      end else if (pick < 97) begin
         rq.req_type = REQ_FREE;
         rq.block_offset_in = OFFSET_W'($urandom_range(UNIT_COUNT - 1) * UNIT_BYTES);
      end
      return rq;
   endfunction

   task automatic issue_request(input bffa_req_type rq, input logic known,
                                input bffa_rsp_type typed_rsp);
      int gap;
      bffa_rsp_type predicted;
      gap = 0;
      if (!calm_tail && $urandom_range(99) < sender_gap_pct) begin
         gap = $urandom_range(19, 1);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = apply_request(rq);
      expected_rsp_q.push_back(known ? typed_rsp : predicted);
   endtask

   task automatic note_mismatch(input bffa_rsp_type want, input logic unexpected);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         if (unexpected) begin
            $display("%0t: response %0d arrived with no request outstanding: %p",
                     $realtime, response_count, rsp_data);
         end else begin
            $display("%0t: response %0d: status %0d want %0d, offset %0d want %0d, frag %0d want %0d",
                     $realtime, response_count, rsp_data.status, want.status,
                     rsp_data.block_offset_out, want.block_offset_out,
                     rsp_data.fragmentation_total, want.fragmentation_total);
         end
      end
   endtask

   always @(negedge clock) begin
      if ($urandom_range(499) == 0) begin
         sink_busy_mode <= !sink_busy_mode;
      end
      if (sink_stall_left > 0) begin
         rsp_ready <= 1'b0;
         sink_stall_left <= sink_stall_left - 1;
      end else if (!calm_tail && sink_busy_mode && $urandom_range(15) == 0) begin
         rsp_ready <= 1'b0;
         sink_stall_left <= $urandom_range(18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      bffa_rsp_type want;
      logic progress;
      progress = (req_valid === 1'b1 && req_ready === 1'b1);
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         progress = 1'b1;
         if (expected_rsp_q.size() == 0) begin
            note_mismatch(rsp_data, 1'b1);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status
                || rsp_data.block_offset_out !== want.block_offset_out
                || rsp_data.fragmentation_total !== want.fragmentation_total) begin
               note_mismatch(want, 1'b0);
            end
         end
         response_count++;
      end
      quiet_cycles <= progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      bffa_req_type rq;
      directed_plan = '{
         plan_entry(1'b1, REQ_ALLOC, 0,     0,     STATUS_ZERO_SIZE, 0,   0),
         plan_entry(1'b1, REQ_ALLOC, 16,    0,     STATUS_OK,        512, 0),
         plan_entry(1'b1, REQ_ALLOC, 1,     0,     STATUS_OK,        528, 15),
         plan_entry(1'b1, REQ_ALLOC, 32767, 0,     STATUS_NO_SPACE,  0,   16),
         plan_entry(1'b1, REQ_ALLOC, 16384, 0,     STATUS_NO_SPACE,  0,   16),
         plan_entry(1'b1, REQ_ALLOC, 15840, 0,     STATUS_OK,        544, 16),
         plan_entry(1'b1, REQ_ALLOC, 1,     0,     STATUS_NO_SPACE,  0,   31),
         plan_entry(1'b1, REQ_FREE,  0,     544,   STATUS_OK,        0,   31),
         plan_entry(1'b1, REQ_FREE,  0,     0,     STATUS_OK,        0,   31),
         plan_entry(1'b1, REQ_FREE,  0,     511,   STATUS_OK,        0,   31),
         plan_entry(1'b1, REQ_FREE,  0,     16383, STATUS_OK,        0,   31),
         plan_entry(1'b1, REQ_FREE,  0,     16368, STATUS_OK,        0,   31),
         plan_entry(1'b1, REQ_ALLOC, 8000,  0,     STATUS_OK,        544, 31),
         plan_entry(1'b0, REQ_ALLOC, 7000,  0,     STATUS_OK,        0,   0),
         plan_entry(1'b0, REQ_FREE,  0,     544,   STATUS_OK,        0,   0),
         plan_entry(1'b0, REQ_ALLOC, 16,    0,     STATUS_OK,        0,   0),
         plan_entry(1'b0, REQ_FREE,  0,     512,   STATUS_OK,        0,   0),
         plan_entry(1'b0, REQ_FREE,  0,     8560,  STATUS_OK,        0,   0),
         plan_entry(1'b0, REQ_FREE,  0,     8544,  STATUS_OK,        0,   0),
         plan_entry(1'b0, REQ_ALLOC, 15824, 0,     STATUS_OK,        0,   0),
         plan_entry(1'b0, REQ_FREE,  0,     560,   STATUS_OK,        0,   0),
         plan_entry(1'b0, REQ_ALLOC, 16383, 0,     STATUS_OK,        0,   0),
         plan_entry(1'b0, REQ_FREE,  32767, 528,   STATUS_OK,        0,   0),
         plan_entry(1'b0, REQ_ALLOC, 17,    16383, STATUS_OK,        0,   0),
         plan_entry(1'b0, REQ_FREE,  0,     520,   STATUS_OK,        0,   0)
      };
      clear_allocator_copy();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         issue_request(directed_plan[row].rq, directed_plan[row].known, directed_plan[row].rs);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(2))
               0: begin
                  sender_gap_pct = 0;
               end
               1: begin
                  sender_gap_pct = 15;
               end
               default: begin
                  sender_gap_pct = 45;
               end
            endcase
         end
         if (n == RANDOM_ITEMS - CALM_ITEMS) begin
            calm_tail = 1'b1;
         end
         rq = random_request();
         issue_request(rq, 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
